// ----- sv/gfla_pkg.sv -----
// Shared types and constants for the growing free-list slot allocator.
// No dependencies; used by the top level and the checker.
package gfla_pkg;

    localparam int HANDLE_W     = 12;
    localparam int HANDLE_SPACE = 1 << HANDLE_W;
    localparam int COUNT_W      = 12;
    localparam int BLOCK_W      = 4;
    localparam int BUMP_W       = HANDLE_W + 1;
    localparam int SIZE_W       = 17;
    localparam int STATUS_W     = 2;

    localparam logic [BLOCK_W-1:0] RECLAIM_RESET = 4'd8;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_OUT_OF_MEM  = 2'd1,
        STATUS_REL_EMPTY   = 2'd2
    } status_t;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

endpackage

// ----- sv/gfla_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gfla_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/growing_free_list_slot_allocator_top.sv -----
// Growing free-list slot allocator: LIFO free list threaded through a link RAM,
// bump pointer over blocks of growing size. Depends on gfla_pkg and gfla_ram.
// Results: release and bump grants give their result beat in the cycle after accept;
// a grant from the free list reads the link RAM in ST_IDLE, then updates in ST_POP.
// Throughput: 1 item per cycle when not stalled; input is held while in ST_POP.
// Reset: asynchronous; clears control state, reclaim threshold to 8, link RAM kept.
module growing_free_list_slot_allocator_top #(
    parameter int UNIT_SLOTS   = 4,
    parameter int MAX_BLOCKS   = 10,
    parameter int GROWTH_STEPS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gfla_pkg::BLOCK_W-1:0]     cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic [gfla_pkg::HANDLE_W-1:0]    slot_handle,
    input  logic                             handle_is_null,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [gfla_pkg::HANDLE_W-1:0]    granted_handle,
    output logic [gfla_pkg::STATUS_W-1:0]    status,
    output logic [gfla_pkg::COUNT_W-1:0]     allocated_count,
    output logic [gfla_pkg::BLOCK_W-1:0]     blocks_open
);

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t                            state_reg, state_next;
    logic [gfla_pkg::HANDLE_W-1:0]     head_reg, head_next;
    logic                              empty_reg, empty_next;
    logic [gfla_pkg::BUMP_W-1:0]       bump_next_reg, bump_next_next;
    logic [gfla_pkg::BUMP_W-1:0]       bump_end_reg, bump_end_next;
    logic [gfla_pkg::BLOCK_W-1:0]      obc_reg, obc_next;
    logic [gfla_pkg::COUNT_W-1:0]      live_reg, live_next;
    logic [gfla_pkg::BLOCK_W-1:0]      reclaim_reg, reclaim_next;

    logic                              out_valid_reg, out_valid_next;
    logic [gfla_pkg::HANDLE_W-1:0]     granted_reg, granted_next;
    logic [gfla_pkg::STATUS_W-1:0]     status_reg, status_next;

    logic                              ram_wr_en;
    logic [gfla_pkg::HANDLE_W-1:0]     ram_wr_addr;
    logic [gfla_pkg::HANDLE_W-1:0]     ram_wr_data;
    logic                              ram_rd_en;
    logic [gfla_pkg::HANDLE_W-1:0]     ram_rd_data;

    logic                              in_fire;
    logic                              out_free;
    logic [gfla_pkg::BLOCK_W-1:0]      shift_amt;
    logic [gfla_pkg::SIZE_W-1:0]       block_size;
    logic [gfla_pkg::SIZE_W:0]         end_sum;
    logic                              blocks_full;
    logic [gfla_pkg::COUNT_W-1:0]      live_dec;

    gfla_ram #(
        .WIDTH (gfla_pkg::HANDLE_W),
        .DEPTH (gfla_pkg::HANDLE_SPACE)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    assign cfg_ready       = 1'b1;
    assign in_stall        = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_fire         = in_valid && !in_stall;
    assign out_free        = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign granted_handle  = granted_reg;
    assign status          = status_reg;
    assign allocated_count = live_reg;
    assign blocks_open     = obc_reg;

    assign shift_amt   = ({1'b0, obc_reg} < 5'(GROWTH_STEPS)) ? obc_reg
                                                               : gfla_pkg::BLOCK_W'(GROWTH_STEPS);
    assign block_size  = gfla_pkg::SIZE_W'(UNIT_SLOTS) << shift_amt;
    assign end_sum     = (gfla_pkg::SIZE_W+1)'(bump_end_reg) + (gfla_pkg::SIZE_W+1)'(block_size);
    assign blocks_full = {1'b0, obc_reg} >= 5'(MAX_BLOCKS);
    assign live_dec    = live_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        bump_next_next = bump_next_reg;
        bump_end_next  = bump_end_reg;
        obc_next       = obc_reg;
        live_next      = live_reg;
        reclaim_next   = reclaim_reg;
        out_valid_next = out_valid_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = slot_handle;
        ram_wr_data    = slot_handle;
        ram_rd_en      = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            reclaim_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == gfla_pkg::KIND_REQUEST)
                    begin
                        if (!empty_reg)
                        begin
                            ram_rd_en  = 1'b1;
                            state_next = ST_POP;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            granted_next   = '0;
                            status_next    = gfla_pkg::STATUS_OK;
                            if (bump_next_reg >= bump_end_reg &&
                                (blocks_full ||
                                 end_sum > (gfla_pkg::SIZE_W+1)'(gfla_pkg::HANDLE_SPACE)))
                            begin
                                status_next = gfla_pkg::STATUS_OUT_OF_MEM;
                            end
                            else
                            begin
                                if (bump_next_reg >= bump_end_reg)
                                begin
                                    bump_end_next = gfla_pkg::BUMP_W'(end_sum);
                                    obc_next      = obc_reg + 1'b1;
                                end
                                granted_next   = bump_next_reg[gfla_pkg::HANDLE_W-1:0];
                                bump_next_next = bump_next_reg + 1'b1;
                                live_next      = live_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        granted_next   = '0;
                        status_next    = gfla_pkg::STATUS_OK;
                        if (!handle_is_null)
                        begin
                            if (live_reg == '0)
                            begin
                                status_next = gfla_pkg::STATUS_REL_EMPTY;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_data = empty_reg ? slot_handle : head_reg;
                                head_next   = slot_handle;
                                empty_next  = 1'b0;
                                live_next   = live_dec;
                                if (live_dec == '0 && obc_reg >= reclaim_reg)
                                begin
                                    obc_next       = '0;
                                    bump_next_next = '0;
                                    bump_end_next  = '0;
                                    head_next      = '0;
                                    empty_next     = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = head_reg;
                    status_next    = gfla_pkg::STATUS_OK;
                    live_next      = live_reg + 1'b1;
                    if (ram_rd_data == head_reg)
                    begin
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        head_next = ram_rd_data;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            empty_reg     <= 1'b1;
            bump_next_reg <= '0;
            bump_end_reg  <= '0;
            obc_reg       <= '0;
            live_reg      <= '0;
            reclaim_reg   <= gfla_pkg::RECLAIM_RESET;
            out_valid_reg <= 1'b0;
            granted_reg   <= '0;
            status_reg    <= gfla_pkg::STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            bump_next_reg <= bump_next_next;
            bump_end_reg  <= bump_end_next;
            obc_reg       <= obc_next;
            live_reg      <= live_next;
            reclaim_reg   <= reclaim_next;
            out_valid_reg <= out_valid_next;
            granted_reg   <= granted_next;
            status_reg    <= status_next;
        end
    end

endmodule

// ----- sv/gfla_checker.sv -----
// Port-level checks for the growing free-list slot allocator, bound to the top.
// Depends on gfla_pkg.
module gfla_checker #(
    parameter int MAX_BLOCKS = 10
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [gfla_pkg::HANDLE_W-1:0] granted_handle,
    input logic [gfla_pkg::STATUS_W-1:0] status,
    input logic [gfla_pkg::COUNT_W-1:0]  allocated_count,
    input logic [gfla_pkg::BLOCK_W-1:0]  blocks_open
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(granted_handle))
        else $error("stalled result beat dropped or changed");

    a_oom_null: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == gfla_pkg::STATUS_OUT_OF_MEM |-> granted_handle == '0)
        else $error("out of memory beat carries a handle");

    a_rel_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == gfla_pkg::STATUS_REL_EMPTY |-> allocated_count == '0)
        else $error("release error with slots allocated");

    a_blocks_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, blocks_open} <= 5'(MAX_BLOCKS))
        else $error("more blocks open than allowed");

endmodule

bind growing_free_list_slot_allocator_top gfla_checker #(
    .MAX_BLOCKS (MAX_BLOCKS)
) u_gfla_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .granted_handle  (granted_handle),
    .status          (status),
    .allocated_count (allocated_count),
    .blocks_open     (blocks_open)
);
